// ===== sv/iqfm_pkg.sv =====
// ----------------------------------------------------------------------------
// iqfm_pkg: shared constants, types and tables
// Sizes for the I/Q boxcar, the pair queue, the discriminator datapath, the
// CORDIC angle pipeline and the audio averager, plus the pair and angle types.
// ----------------------------------------------------------------------------
package iqfm_pkg;

  // Decimation factors
  localparam int DECIM_IQ    = 5;
  localparam int DECIM_AUDIO = 2;

  // Raw byte offset
  localparam logic signed [8:0] CENTER = 9'sd127;

  // Boxcar sums: centered bytes span -127..128
  localparam int IQC_W = (DECIM_IQ > 1) ? $clog2(DECIM_IQ) : 1;
  localparam int SUM_W = $clog2(128 * DECIM_IQ + 1) + 1;

  // Conjugate product and CORDIC vector
  localparam int PROD_W       = 2 * SUM_W;
  localparam int RE_W         = PROD_W + 1;
  localparam int PRESCALE     = 16;
  localparam int CW           = RE_W + PRESCALE + 2;
  localparam int CORDIC_STEPS = 14;
  localparam int Z_W          = 18;
  localparam int ANG_W        = 16;

  localparam logic signed [Z_W-1:0] HALF_TURN = Z_W'(32768);
  localparam logic signed [Z_W-1:0] ANG_MAX   = Z_W'(32767);

  // Audio averager: exact floor(mag / DECIM_AUDIO) by reciprocal multiply
  localparam int LOG_DA  = $clog2(DECIM_AUDIO);
  localparam int PC_W    = (DECIM_AUDIO > 1) ? LOG_DA : 1;
  localparam int PS_W    = ANG_W + LOG_DA + 1;
  localparam int MAG_W   = ANG_W + LOG_DA;
  localparam int DIV_SH  = MAG_W + LOG_DA;
  localparam int RECIP_W = MAG_W + 1;
  localparam longint RECIP_L = ((longint'(1) << DIV_SH) + DECIM_AUDIO - 1) / DECIM_AUDIO;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);
  localparam int LO_W    = MAG_W / 2;
  localparam int HI_W    = MAG_W - LO_W;
  localparam int PL_W    = LO_W + RECIP_W;
  localparam int PH_W    = HI_W + RECIP_W;
  localparam int FULL_W  = MAG_W + RECIP_W;

  // Pair queue between front and back
  localparam int FIFO_DEPTH = 4;
  localparam int FPTR_W     = $clog2(FIFO_DEPTH);
  localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic signed [SUM_W-1:0] i;
    logic signed [SUM_W-1:0] q;
  } pair_t;

  typedef struct packed {
    logic                    vld;
    logic signed [ANG_W-1:0] ang;
  } angle_t;

  // atan(2^-k) in units of pi/32768
  function automatic logic signed [Z_W-1:0] atan_lut(input int k);
    case (k)
      0:       atan_lut = Z_W'(8192);
      1:       atan_lut = Z_W'(4836);
      2:       atan_lut = Z_W'(2555);
      3:       atan_lut = Z_W'(1297);
      4:       atan_lut = Z_W'(651);
      5:       atan_lut = Z_W'(326);
      6:       atan_lut = Z_W'(163);
      7:       atan_lut = Z_W'(81);
      8:       atan_lut = Z_W'(41);
      9:       atan_lut = Z_W'(20);
      10:      atan_lut = Z_W'(10);
      11:      atan_lut = Z_W'(5);
      12:      atan_lut = Z_W'(3);
      13:      atan_lut = Z_W'(1);
      default: atan_lut = '0;
    endcase
  endfunction

endpackage

// ===== sv/iqfm_front.sv =====
// ----------------------------------------------------------------------------
// iqfm_front: input stage and I/Q boxcar
// Centers each raw byte pair and sums DECIM_IQ of them into one decimated
// pair, which is pushed into the pair queue.
// ----------------------------------------------------------------------------
module iqfm_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_i_byte,
  input  logic [7:0]          in_q_byte,
  input  logic                q_full,
  output logic                q_push,
  output iqfm_pkg::pair_t     q_data
);
  import iqfm_pkg::*;

  logic signed [SUM_W-1:0] sum_i_r, sum_q_r, sum_i_nxt, sum_q_nxt;
  logic [IQC_W-1:0]        cnt_r;
  logic signed [8:0]       ci, cq;
  logic                    acc, last;

  // Hold off while the queue is full
  assign in_ready = !q_full;
  assign acc      = in_valid && in_ready;
  assign last     = (cnt_r == IQC_W'(DECIM_IQ - 1));

  always_comb begin
    ci        = $signed({1'b0, in_i_byte}) - CENTER;
    cq        = $signed({1'b0, in_q_byte}) - CENTER;
    sum_i_nxt = sum_i_r + SUM_W'(ci);
    sum_q_nxt = sum_q_r + SUM_W'(cq);
  end

  assign q_push = acc && last;
  assign q_data = '{i: sum_i_nxt, q: sum_q_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_i_r <= '0;
      sum_q_r <= '0;
      cnt_r   <= '0;
    end else if (acc) begin
      if (last) begin
        sum_i_r <= '0;
        sum_q_r <= '0;
        cnt_r   <= '0;
      end else begin
        sum_i_r <= sum_i_nxt;
        sum_q_r <= sum_q_nxt;
        cnt_r   <= cnt_r + 1'b1;
      end
    end
  end

endmodule

// ===== sv/iqfm_fifo.sv =====
// ----------------------------------------------------------------------------
// iqfm_fifo: decimated pair queue
// Short first-in first-out queue that lets the front and back stall apart.
// ----------------------------------------------------------------------------
module iqfm_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  iqfm_pkg::pair_t push_data,
  output logic            full,
  input  logic            pop,
  output iqfm_pkg::pair_t pop_data,
  output logic            empty
);
  import iqfm_pkg::*;

  pair_t             mem_r [FIFO_DEPTH];
  logic [FPTR_W-1:0] wr_r, rd_r;
  logic [FCNT_W-1:0] cnt_r;
  logic              do_push, do_pop;

  assign full     = (cnt_r == FCNT_W'(FIFO_DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wr_r <= (wr_r == FPTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_r + 1'b1;
      end
      if (do_pop) begin
        rd_r <= (rd_r == FPTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_r + 1'b1;
      end
      cnt_r <= cnt_r + FCNT_W'(do_push) - FCNT_W'(do_pop);
    end
  end

endmodule

// ===== sv/iqfm_disc.sv =====
// ----------------------------------------------------------------------------
// iqfm_disc: quadrature discriminator
// Multiplies each decimated pair by the conjugate of the previous one and
// finds the phase of the product with a pipelined vectoring CORDIC.
// ----------------------------------------------------------------------------
module iqfm_disc (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic             q_empty,
  output logic             q_pop,
  input  iqfm_pkg::pair_t  q_data,
  output iqfm_pkg::angle_t ang_o
);
  import iqfm_pkg::*;

  pair_t                    last_r, cur_a_r, prev_a_r;
  logic                     have_last_r, vld_a_r, vld_b_r, vld_c_r;
  logic signed [PROD_W-1:0] ii_r, qq_r, qi_r, iq_r;
  logic signed [RE_W-1:0]   re_r, im_r;

  logic signed [CW-1:0]     x_r   [CORDIC_STEPS+1];
  logic signed [CW-1:0]     y_r   [CORDIC_STEPS+1];
  logic signed [Z_W-1:0]    z_r   [CORDIC_STEPS+1];
  logic signed [CW-1:0]     x_nxt [CORDIC_STEPS+1];
  logic signed [CW-1:0]     y_nxt [CORDIC_STEPS+1];
  logic signed [Z_W-1:0]    z_nxt [CORDIC_STEPS+1];
  logic signed [CW-1:0]     xs    [CORDIC_STEPS];
  logic signed [CW-1:0]     ys    [CORDIC_STEPS];
  logic [CORDIC_STEPS:0]    vld_r, zero_r;
  logic                     zero_nxt;
  logic signed [Z_W-1:0]    z_out;
  logic signed [ANG_W-1:0]  ang_sat;

  assign q_pop = adv && !q_empty;

  // Pre-rotation into the right half plane, then the CORDIC steps
  always_comb begin
    x_nxt[0] = CW'(re_r) <<< PRESCALE;
    y_nxt[0] = CW'(im_r) <<< PRESCALE;
    z_nxt[0] = '0;
    if (re_r < 0) begin
      z_nxt[0] = (im_r >= 0) ? HALF_TURN : -HALF_TURN;
      x_nxt[0] = -(CW'(re_r) <<< PRESCALE);
      y_nxt[0] = -(CW'(im_r) <<< PRESCALE);
    end
    zero_nxt = (re_r == '0) && (im_r == '0);
    for (int k = 0; k < CORDIC_STEPS; k++) begin
      xs[k] = x_r[k] >>> k;
      ys[k] = y_r[k] >>> k;
      if (y_r[k] > 0) begin
        x_nxt[k+1] = x_r[k] + ys[k];
        y_nxt[k+1] = y_r[k] - xs[k];
        z_nxt[k+1] = z_r[k] + atan_lut(k);
      end else begin
        x_nxt[k+1] = x_r[k] - ys[k];
        y_nxt[k+1] = y_r[k] + xs[k];
        z_nxt[k+1] = z_r[k] - atan_lut(k);
      end
    end
  end

  // Control: valid flags and first-pair tracking
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_last_r <= 1'b0;
      vld_a_r     <= 1'b0;
      vld_b_r     <= 1'b0;
      vld_c_r     <= 1'b0;
      vld_r       <= '0;
    end else if (adv) begin
      if (q_pop) begin
        have_last_r <= 1'b1;
      end
      vld_a_r <= q_pop && have_last_r;
      vld_b_r <= vld_a_r;
      vld_c_r <= vld_b_r;
      vld_r   <= {vld_r[CORDIC_STEPS-1:0], vld_c_r};
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (adv) begin
      if (q_pop) begin
        last_r <= q_data;
      end
      cur_a_r  <= q_data;
      prev_a_r <= last_r;
      ii_r     <= PROD_W'(cur_a_r.i) * PROD_W'(prev_a_r.i);
      qq_r     <= PROD_W'(cur_a_r.q) * PROD_W'(prev_a_r.q);
      qi_r     <= PROD_W'(cur_a_r.q) * PROD_W'(prev_a_r.i);
      iq_r     <= PROD_W'(cur_a_r.i) * PROD_W'(prev_a_r.q);
      re_r     <= RE_W'(ii_r) + RE_W'(qq_r);
      im_r     <= RE_W'(qi_r) - RE_W'(iq_r);
      zero_r   <= {zero_r[CORDIC_STEPS-1:0], zero_nxt};
      for (int k = 0; k <= CORDIC_STEPS; k++) begin
        x_r[k] <= x_nxt[k];
        y_r[k] <= y_nxt[k];
        z_r[k] <= z_nxt[k];
      end
    end
  end

  // Saturate to the 16-bit angle range; a zero product reads as angle 0
  always_comb begin
    z_out = z_r[CORDIC_STEPS];
    if (zero_r[CORDIC_STEPS]) begin
      ang_sat = '0;
    end else if (z_out > ANG_MAX) begin
      ang_sat = ANG_W'(ANG_MAX);
    end else if (z_out < -HALF_TURN) begin
      ang_sat = ANG_W'(-HALF_TURN);
    end else begin
      ang_sat = z_out[ANG_W-1:0];
    end
  end

  assign ang_o = '{vld: vld_r[CORDIC_STEPS], ang: ang_sat};

endmodule

// ===== sv/iqfm_avg.sv =====
// ----------------------------------------------------------------------------
// iqfm_avg: audio averager and output register
// Sums DECIM_AUDIO angles, divides by DECIM_AUDIO toward zero and holds the
// audio sample until it is taken. Drives the pipeline advance.
// ----------------------------------------------------------------------------
module iqfm_avg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  iqfm_pkg::angle_t                 ang_i,
  output logic                             adv,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [iqfm_pkg::ANG_W-1:0] out_audio_sample
);
  import iqfm_pkg::*;

  logic signed [PS_W-1:0]  ps_r, ps_nxt, sum_f_r, mag_full;
  logic [PC_W-1:0]         pc_r;
  logic                    done, vld_f_r, vld_g_r, neg_g_r, out_valid_r;
  logic [MAG_W-1:0]        mag;
  logic [PL_W-1:0]         pl_nxt, pl_g_r;
  logic [PH_W-1:0]         ph_nxt, ph_g_r;
  logic [FULL_W-1:0]       full;
  logic [ANG_W-1:0]        quo;
  logic signed [ANG_W-1:0] res_nxt, out_audio_sample_r;

  // Advance everything when the output register is free or being taken
  assign adv  = !out_valid_r || out_ready;
  assign done = (pc_r == PC_W'(DECIM_AUDIO - 1));

  always_comb begin
    ps_nxt   = ps_r + PS_W'(ang_i.ang);
    mag_full = (sum_f_r < 0) ? -sum_f_r : sum_f_r;
    mag      = mag_full[MAG_W-1:0];
    pl_nxt   = PL_W'(mag[LO_W-1:0]) * PL_W'(RECIP);
    ph_nxt   = PH_W'(mag[MAG_W-1:LO_W]) * PH_W'(RECIP);
    full     = (FULL_W'(ph_g_r) << LO_W) + FULL_W'(pl_g_r);
    quo      = ANG_W'(full >> DIV_SH);
    res_nxt  = neg_g_r ? -$signed(quo) : $signed(quo);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ps_r        <= '0;
      pc_r        <= '0;
      vld_f_r     <= 1'b0;
      vld_g_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      if (ang_i.vld) begin
        if (done) begin
          ps_r <= '0;
          pc_r <= '0;
        end else begin
          ps_r <= ps_nxt;
          pc_r <= pc_r + 1'b1;
        end
      end
      vld_f_r     <= ang_i.vld && done;
      vld_g_r     <= vld_f_r;
      out_valid_r <= vld_g_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sum_f_r            <= ps_nxt;
      neg_g_r            <= (sum_f_r < 0);
      pl_g_r             <= pl_nxt;
      ph_g_r             <= ph_nxt;
      out_audio_sample_r <= res_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_audio_sample = out_audio_sample_r;

endmodule

// ===== sv/iq_decimate_fm_demodulator_core.sv =====
// ----------------------------------------------------------------------------
// iq_decimate_fm_demodulator_core: FM discriminator with boxcar decimation
// Raw I/Q byte pairs in, averaged phase-difference audio samples out.
// ----------------------------------------------------------------------------
// The block takes one raw I/Q byte pair per clock unless stalled and gives one
// 16-bit audio sample for every DECIM_IQ * DECIM_AUDIO pairs (10 with the
// package values), except that the first DECIM_IQ pairs after reset only
// prime the discriminator. Each byte is centered by subtracting 127 and
// DECIM_IQ centered pairs are summed (not divided). Each decimated pair is
// multiplied by the conjugate of the previous one and the phase of that
// product is found by a 14-stage pipelined CORDIC; 32768 stands for pi and
// the angle saturates at 32767. DECIM_AUDIO angles are averaged, truncating
// toward zero, into one sample. The pair that completes a sample passes the
// pair queue, the conjugate multiply (three stages), the CORDIC (pre-rotation
// plus fourteen steps) and the averager (three stages) before out_valid rises.
// The front accumulator and the back pipeline are split by a four-entry pair
// queue; a stalled output freezes the back pipeline, and in_ready drops only
// once that queue is full.
// ----------------------------------------------------------------------------
module iq_decimate_fm_demodulator_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [7:0]                        in_i_byte,
  input  logic [7:0]                        in_q_byte,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [iqfm_pkg::ANG_W-1:0] out_audio_sample
);
  import iqfm_pkg::*;

  pair_t  push_data, pop_data;
  angle_t ang;
  logic   q_push, q_full, q_pop, q_empty, adv;

  // Center and boxcar-sum the incoming requests
  iqfm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_i_byte (in_i_byte),
    .in_q_byte (in_q_byte),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (push_data)
  );

  // Hold decimated pairs while the back end stalls
  iqfm_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (pop_data),
    .empty     (q_empty)
  );

  // Conjugate multiply and CORDIC phase
  iqfm_disc u_disc (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .q_data  (pop_data),
    .ang_o   (ang)
  );

  // Average angles and drive the result channel
  iqfm_avg u_avg (
    .clk              (clk),
    .rst_n            (rst_n),
    .ang_i            (ang),
    .adv              (adv),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_audio_sample (out_audio_sample)
  );

endmodule

// ===== tb/tb_iq_decimate_fm_demodulator_core.sv =====
// ----------------------------------------------------------------------------
// tb_iq_decimate_fm_demodulator_core: self-checking bench for the FM core
// Drives raw I/Q byte pairs with bursty valid timing and a stalling sink.
// An in-bench discriminator predicts each audio sample and every returned
// sample is compared in order against it.
// ----------------------------------------------------------------------------
module tb_iq_decimate_fm_demodulator_core;
  timeunit 1ns;
  timeprecision 1ps;

  import iqfm_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 48;
  localparam int ITEM_TARGET  = 1100;
  localparam int RAW_CENTER   = 127;
  localparam int ARC_STEPS    = 14;
  localparam int MAX_REPORTS  = 10;

  // --------------------------------------------------------------------------
  // Audio scoreboard: boxcar sums, conjugate product, CORDIC phase and the
  // audio average, kept in step with every accepted request.
  // --------------------------------------------------------------------------
  class audio_scoreboard;
    int        acc_i, acc_q;
    int        acc_count;
    int        prev_i, prev_q;
    bit        prev_valid;
    int        angle_sum;
    int        angle_count;
    shortint   audio_expected[$];
    int        mismatches;
    int        atan_step[ARC_STEPS] = '{8192, 4836, 2555, 1297, 651, 326, 163,
                                        81, 41, 20, 10, 5, 3, 1};

    // Phase of re + j*im in units of pi/32768, saturated to 16 bits.
    function int phase_angle(longint re, longint im);
      longint x, y, z, xs, ys;
      if (re == 0 && im == 0) return 0;
      x = re * 65536;
      y = im * 65536;
      z = 0;
      // Fold the left half plane onto the right and start from +/- pi.
      if (x < 0) begin
        z = (y >= 0) ? 32768 : -32768;
        x = -x;
        y = -y;
      end
      for (int k = 0; k < ARC_STEPS; k++) begin
        xs = x >>> k;
        ys = y >>> k;
        if (y > 0) begin
          x = x + ys;
          y = y - xs;
          z = z + atan_step[k];
        end else begin
          x = x - ys;
          y = y + xs;
          z = z - atan_step[k];
        end
      end
      if (z > 32767) z = 32767;
      if (z < -32768) z = -32768;
      return int'(z);
    endfunction

    function void note_request(logic [7:0] i_b, logic [7:0] q_b);
      int     dec_i, dec_q, angle;
      longint re, im;
      acc_i += int'(i_b) - RAW_CENTER;
      acc_q += int'(q_b) - RAW_CENTER;
      acc_count++;
      if (acc_count < DECIM_IQ) return;
      dec_i = acc_i;
      dec_q = acc_q;
      acc_i = 0;
      acc_q = 0;
      acc_count = 0;
      // The first decimated pair only primes the discriminator.
      if (!prev_valid) begin
        prev_i = dec_i;
        prev_q = dec_q;
        prev_valid = 1;
        return;
      end
      re = longint'(dec_i) * prev_i + longint'(dec_q) * prev_q;
      im = longint'(dec_q) * prev_i - longint'(dec_i) * prev_q;
      angle = phase_angle(re, im);
      prev_i = dec_i;
      prev_q = dec_q;
      angle_sum += angle;
      angle_count++;
      if (angle_count < DECIM_AUDIO) return;
      // Integer division truncates toward zero, as the averager does.
      audio_expected.push_back(shortint'(angle_sum / DECIM_AUDIO));
      angle_sum = 0;
      angle_count = 0;
    endfunction

    function void check_sample(logic signed [ANG_W-1:0] actual);
      shortint want;
      if (audio_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected audio sample %0d, none pending", actual);
        return;
      end
      want = audio_expected.pop_front();
      if (want !== actual) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("audio sample mismatch: expected %0d, got %0d", want, actual);
      end
    endfunction

    function int pending();
      return audio_expected.size();
    endfunction
  endclass

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_ready;
  logic [7:0]               in_i_byte;
  logic [7:0]               in_q_byte;
  logic                     out_valid;
  logic                     out_ready;
  logic signed [ANG_W-1:0]  out_audio_sample;

  audio_scoreboard sb;
  int              cycle_count = 0;
  int              burst_left;
  int              items_sent;

  iq_decimate_fm_demodulator_core u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_i_byte        (in_i_byte),
    .in_q_byte        (in_q_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_audio_sample (out_audio_sample)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: abort a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Monitor both channels at the rising edge; values were set at the falling
  // edge, so they are stable here.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_request(in_i_byte, in_q_byte);
      if (out_valid && out_ready) sb.check_sample(out_audio_sample);
    end
  end

  // Sink: pick a new stall pattern for each window. Always-ready windows give
  // stretches with no back-pressure; the long-stall window fills the pair
  // queue so in_ready drops.
  initial begin
    int mode;
    int window;
    mode = 0;
    window = 0;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (window == 0) begin
        mode = $urandom_range(0, 4);
        window = 200;
      end
      window--;
      case (mode)
        0: out_ready = 1'b1;
        1: out_ready = window[0];
        2: out_ready = (window[1:0] == 2'b00);
        3: out_ready = ($urandom_range(0, 9) < 6);
        default: out_ready = (window % 50) >= 30;
      endcase
    end
  end

  // Send one request: open a new burst after a random gap when the current
  // one is used up, then hold valid and payload until accepted.
  task automatic send_request(input logic [7:0] i_b, input logic [7:0] q_b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 48);
    end
    in_valid  = 1'b1;
    in_i_byte = i_b;
    in_q_byte = q_b;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    burst_left--;
    items_sent++;
  endtask

  // Send one decimation group of identical pairs.
  task automatic send_group(input logic [7:0] i_b, input logic [7:0] q_b);
    repeat (DECIM_IQ) send_request(i_b, q_b);
  endtask

  initial begin
    int          mode;
    logic [7:0]  hold_i, hold_q;
    logic [7:0]  corner[4];
    sb = new();
    corner = '{8'd0, 8'd127, 8'd128, 8'd255};
    burst_left  = 0;
    items_sent  = 0;
    in_valid  = 1'b0;
    in_i_byte = 8'd0;
    in_q_byte = 8'd0;
    rst_n     = 1'b0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // Directed: prime with the largest positive pair, then a pair pointing
    // the opposite way (angle of exactly pi, saturates high), then the zero
    // pair (zero product), then a zero previous pair, then a left half plane
    // product with negative imaginary part (start from minus pi).
    send_group(8'd255, 8'd255);
    send_group(8'd0,   8'd0);
    send_group(8'd127, 8'd127);
    send_group(8'd0,   8'd255);
    send_group(8'd255, 8'd0);

    // Random: one content style per decimation group.
    while (items_sent < ITEM_TARGET) begin
      mode   = $urandom_range(0, 9);
      hold_i = 8'($urandom_range(0, 255));
      hold_q = 8'($urandom_range(0, 255));
      for (int n = 0; n < DECIM_IQ; n++) begin
        if (mode < 5)
          send_request(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        else if (mode < 7)
          send_request(hold_i, hold_q);
        else if (mode < 9)
          send_request(corner[2'($urandom_range(0, 3))],
                       corner[2'($urandom_range(0, 3))]);
        else
          send_request(8'($urandom_range(124, 130)), 8'($urandom_range(124, 130)));
      end
    end
    in_valid = 1'b0;

    // Drain: wait for every expected sample, then watch for strays.
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
